FILE: rtl/lpd_pkg.sv
// shared types, constants and helpers for the log packet deframer
`timescale 1ns / 1ps

package lpd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_GT = 8'h3E;

    localparam logic [7:0] PKT_RAW_ADC = 8'h00;
    localparam logic [7:0] PKT_CAL     = 8'h01;
    localparam logic [7:0] PKT_STAMP   = 8'h02;

    localparam logic KIND_RAW = 1'b0;
    localparam logic KIND_CAL = 1'b1;

    localparam int TDATA_W = 72;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] sample_value;
        logic [7:0]  sample_index;
        logic        last;
        logic [7:0]  gain_level;
        logic [7:0]  current_tenths_ma;
        logic [15:0] cal_raw_value;
        logic [15:0] cal_timestamp;
    } lpd_result_t;

    // little-endian byte placement into a 16-bit word, bytes past the second drop out
    function automatic logic [15:0] place_byte(input logic [7:0] b, input logic [2:0] pos);
        logic [15:0] w;
        case (pos)
            3'd0:    w = {8'h00, b};
            3'd1:    w = {b, 8'h00};
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/lpd_core.sv
// marker hunt and packet parser: one byte per step, result built combinationally
`timescale 1ns / 1ps

module lpd_core #(
    parameter int SAMPLE_BYTES = 2,
    parameter int STAMP_BYTES  = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    output logic                 res_valid,
    output lpd_pkg::lpd_result_t res
);

    typedef enum logic [1:0] {FR_HUNT, FR_TYPE, FR_LEN, FR_PAYLOAD} frame_t;
    typedef enum logic [1:0] {PP_FIRST, PP_RAW, PP_CURRENT, PP_STAMP} pphase_t;

    // history_reg[2] is the newest byte
    logic [7:0]  history_reg [3];
    logic [7:0]  history_next [3];
    frame_t      frame_reg, frame_next;
    logic [7:0]  type_reg, type_next;
    pphase_t     pphase_reg, pphase_next;
    logic [2:0]  bcount_reg, bcount_next;
    logic [7:0]  total_reg, total_next;
    logic [7:0]  scount_reg, scount_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0]  pga_reg, pga_next;
    logic [7:0]  cur_reg, cur_next;
    logic [15:0] craw_reg, craw_next;

    logic [2:0]  bcount_inc;
    logic [15:0] acc_placed;
    logic [15:0] craw_placed;
    logic [8:0]  scount_inc;
    logic        marker_hit;

    always_comb begin
        bcount_inc  = bcount_reg + 3'd1;
        acc_placed  = acc_reg | lpd_pkg::place_byte(data_byte, bcount_reg);
        craw_placed = craw_reg | lpd_pkg::place_byte(data_byte, bcount_reg);
        scount_inc  = {1'b0, scount_reg} + 9'd1;
        marker_hit  = (history_reg[0] == lpd_pkg::CH_CR) && (history_reg[1] == lpd_pkg::CH_LF)
                   && (history_reg[2] == lpd_pkg::CH_GT) && (data_byte == lpd_pkg::CH_GT);
    end

    always_comb begin
        history_next = history_reg;
        frame_next   = frame_reg;
        type_next    = type_reg;
        pphase_next  = pphase_reg;
        bcount_next  = bcount_reg;
        total_next   = total_reg;
        scount_next  = scount_reg;
        acc_next     = acc_reg;
        pga_next     = pga_reg;
        cur_next     = cur_reg;
        craw_next    = craw_reg;
        res_valid    = 1'b0;
        res          = '0;

        unique case (frame_reg)
            FR_HUNT: begin
                history_next[0] = history_reg[1];
                history_next[1] = history_reg[2];
                history_next[2] = data_byte;
                if (marker_hit) begin
                    frame_next  = FR_TYPE;
                    type_next   = 8'h00;
                    pphase_next = PP_FIRST;
                    bcount_next = 3'd0;
                    total_next  = 8'h00;
                    scount_next = 8'h00;
                    acc_next    = 16'h0000;
                    pga_next    = 8'h00;
                    cur_next    = 8'h00;
                    craw_next   = 16'h0000;
                end
            end
            FR_TYPE: begin
                type_next  = data_byte;
                frame_next = FR_LEN;
            end
            FR_LEN: begin
                frame_next = FR_PAYLOAD;
            end
            FR_PAYLOAD: begin
                case (type_reg)
                    lpd_pkg::PKT_RAW_ADC: begin
                        if (pphase_reg == PP_FIRST) begin
                            total_next  = data_byte;
                            pphase_next = PP_RAW;
                        end else if (bcount_inc < 3'(SAMPLE_BYTES)) begin
                            acc_next    = acc_placed;
                            bcount_next = bcount_inc;
                        end else begin
                            bcount_next      = 3'd0;
                            acc_next         = 16'h0000;
                            res_valid        = 1'b1;
                            res.record_kind  = lpd_pkg::KIND_RAW;
                            res.sample_value = acc_placed;
                            res.sample_index = scount_reg;
                            // a count of zero behaves as a count of one
                            if (scount_inc >= {1'b0, total_reg}) begin
                                res.last    = 1'b1;
                                scount_next = 8'h00;
                                frame_next  = FR_HUNT;
                            end else begin
                                scount_next = scount_inc[7:0];
                            end
                        end
                    end
                    lpd_pkg::PKT_CAL: begin
                        unique case (pphase_reg)
                            PP_FIRST: begin
                                pga_next    = data_byte;
                                pphase_next = PP_RAW;
                            end
                            PP_RAW: begin
                                craw_next = craw_placed;
                                if (bcount_inc >= 3'(SAMPLE_BYTES)) begin
                                    bcount_next = 3'd0;
                                    pphase_next = PP_CURRENT;
                                end else begin
                                    bcount_next = bcount_inc;
                                end
                            end
                            PP_CURRENT: begin
                                cur_next    = data_byte;
                                pphase_next = PP_STAMP;
                            end
                            PP_STAMP: begin
                                acc_next = acc_placed;
                                if (bcount_inc < 3'(STAMP_BYTES)) begin
                                    bcount_next = bcount_inc;
                                end else begin
                                    bcount_next           = 3'd0;
                                    frame_next            = FR_HUNT;
                                    res_valid             = 1'b1;
                                    res.record_kind       = lpd_pkg::KIND_CAL;
                                    res.last              = 1'b1;
                                    res.gain_level        = pga_reg;
                                    res.current_tenths_ma = cur_reg;
                                    res.cal_raw_value     = craw_reg;
                                    res.cal_timestamp     = acc_placed;
                                end
                            end
                            default: ;
                        endcase
                    end
                    // timestamp and unknown types: drop the byte and hunt again
                    default: frame_next = FR_HUNT;
                endcase
            end
            default: frame_next = FR_HUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg <= '{8'h00, 8'h00, 8'h00};
            frame_reg   <= FR_HUNT;
            type_reg    <= 8'h00;
            pphase_reg  <= PP_FIRST;
            bcount_reg  <= 3'd0;
            total_reg   <= 8'h00;
            scount_reg  <= 8'h00;
            acc_reg     <= 16'h0000;
            pga_reg     <= 8'h00;
            cur_reg     <= 8'h00;
            craw_reg    <= 16'h0000;
        end else if (step) begin
            history_reg <= history_next;
            frame_reg   <= frame_next;
            type_reg    <= type_next;
            pphase_reg  <= pphase_next;
            bcount_reg  <= bcount_next;
            total_reg   <= total_next;
            scount_reg  <= scount_next;
            acc_reg     <= acc_next;
            pga_reg     <= pga_next;
            cur_reg     <= cur_next;
            craw_reg    <= craw_next;
        end
    end

    property p_bcount_bounded;
        @(posedge aclk) disable iff (!aresetn)
        bcount_reg < 3'd4;
    endproperty
    a_bcount_bounded: assert property (p_bcount_bounded)
        else $error("byte counter out of range");

    property p_result_ends_or_continues;
        @(posedge aclk) disable iff (!aresetn)
        step && res_valid && res.last |=> frame_reg == FR_HUNT;
    endproperty
    a_result_ends: assert property (p_result_ends_or_continues)
        else $error("final result did not return to hunting");

    property p_result_only_in_payload;
        @(posedge aclk) disable iff (!aresetn)
        res_valid |-> frame_reg == FR_PAYLOAD;
    endproperty
    a_result_payload: assert property (p_result_only_in_payload)
        else $error("result outside payload");

endmodule

FILE: rtl/lpd_out_stage.sv
// result register between the parser and the output stream
`timescale 1ns / 1ps

module lpd_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  lpd_pkg::lpd_result_t        res,
    output logic                        free,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lpd_pkg::TDATA_W-1:0] m_tdata,
    output logic [0:0]                  m_tuser,
    output logic                        m_tlast
);

    logic                 valid_reg;
    lpd_pkg::lpd_result_t data_reg;

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.record_kind;
    assign m_tlast  = data_reg.last;
    assign m_tdata  = {data_reg.cal_timestamp, data_reg.cal_raw_value,
                       data_reg.current_tenths_ma, data_reg.gain_level,
                       data_reg.sample_index, data_reg.sample_value};

endmodule

FILE: rtl/log_packet_deframer_top.sv
// top level of the log packet deframer
`timescale 1ns / 1ps

// Byte-stream deframer for a binary log link. Bytes enter on s_tdata; the block
// hunts for CR LF '>' '>', then reads type and length bytes and the payload.
// Type 0 yields one beat per finished ADC sample (tlast on the final one, a
// count of zero counts as one); type 1 yields one calibration beat; other
// types drop back to hunting. Each input byte is registered, parsed by the
// state logic, and its result lands in the output register, so a new beat
// is taken each cycle while m_tready keeps up.

module log_packet_deframer_top #(
    parameter int SAMPLE_BYTES = 2,
    parameter int STAMP_BYTES  = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] data_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] sample_value, [23:16] sample_index, [31:24] gain_level,
    // [39:32] current_tenths_ma, [55:40] cal_raw_value, [71:56] cal_timestamp
    output logic [lpd_pkg::TDATA_W-1:0] m_tdata,
    output logic [0:0]                  m_tuser,  // [0] record_kind
    output logic                        m_tlast
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_free;
    logic                 advance;
    logic                 res_valid;
    lpd_pkg::lpd_result_t res;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    lpd_core #(
        .SAMPLE_BYTES (SAMPLE_BYTES),
        .STAMP_BYTES  (STAMP_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    property p_cal_is_last;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast;
    endproperty
    a_cal_is_last: assert property (p_cal_is_last)
        else $error("calibration beat without tlast");

    property p_cal_no_sample;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[23:0] == 24'h000000;
    endproperty
    a_cal_no_sample: assert property (p_cal_no_sample)
        else $error("calibration beat carries sample fields");

    property p_raw_no_cal;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[71:24] == 48'h0;
    endproperty
    a_raw_no_cal: assert property (p_raw_no_cal)
        else $error("sample beat carries calibration fields");

    property p_held_byte;
        @(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg);
    endproperty
    a_held_byte: assert property (p_held_byte)
        else $error("pending input byte lost");

endmodule

FILE: test/log_packet_deframer_checker.sv
// beat checker for the log packet deframer: predicts every result beat and compares it
`timescale 1ns / 1ps

module log_packet_deframer_checker #(
    parameter int SAMPLE_BYTES = 2,
    parameter int STAMP_BYTES  = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] sample_value, [23:16] sample_index, [31:24] gain_level,
    // [39:32] current_tenths_ma, [55:40] cal_raw_value, [71:56] cal_timestamp
    input  logic [lpd_pkg::TDATA_W-1:0] m_tdata,
    input  logic [0:0]                  m_tuser,   // [0] record_kind
    input  logic                        m_tlast,
    output int                          errors,
    output int                          pending,
    output int                          raw_seen,
    output int                          cal_seen
);

    typedef enum logic [1:0] {HUNT, TYPE_BYTE, LEN_BYTE, PAYLOAD} frame_phase_e;
    typedef enum logic [1:0] {CAL_PGA, CAL_RAW, CAL_CURRENT, CAL_STAMP} cal_field_e;

    // parser state kept alongside the block
    logic [7:0]   history [4];
    logic [1:0]   hist_ptr;
    frame_phase_e phase;
    logic [7:0]   pkt_type;
    logic         count_known;
    cal_field_e   cal_field;
    logic [2:0]   byte_cnt;
    logic [7:0]   n_samples;
    logic [7:0]   sample_idx;
    logic [15:0]  word;
    logic [7:0]   pga;
    logic [7:0]   current;
    logic [15:0]  cal_raw;

    lpd_pkg::lpd_result_t pending_beats[$];
    int mismatch_cnt = 0;
    int raw_cnt = 0;
    int cal_cnt = 0;

    // little-endian lane of a byte, bytes past the second add nothing
    function automatic logic [15:0] byte_lane(input logic [7:0] b, input logic [2:0] pos);
        return (pos < 3'd2) ? (16'(b) << (8 * pos)) : 16'h0000;
    endfunction

    task automatic clear_packet();
        pkt_type    = lpd_pkg::PKT_RAW_ADC;
        count_known = 1'b0;
        cal_field   = CAL_PGA;
        byte_cnt    = '0;
        n_samples   = '0;
        sample_idx  = '0;
        word        = '0;
        pga         = '0;
        current     = '0;
        cal_raw     = '0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, output bit fire,
                                output lpd_pkg::lpd_result_t r);
        logic [1:0] p;
        fire = 1'b0;
        r    = '0;
        case (phase)
            HUNT: begin
                history[hist_ptr] = b;
                hist_ptr = hist_ptr + 2'd1;
                p = hist_ptr;
                if (history[p] == lpd_pkg::CH_CR && history[p + 2'd1] == lpd_pkg::CH_LF &&
                    history[p + 2'd2] == lpd_pkg::CH_GT &&
                    history[p + 2'd3] == lpd_pkg::CH_GT) begin
                    clear_packet();
                    phase = TYPE_BYTE;
                end
            end
            TYPE_BYTE: begin
                pkt_type = b;
                phase = LEN_BYTE;
            end
            LEN_BYTE: begin
                phase = PAYLOAD;
            end
            default: begin
                if (pkt_type == lpd_pkg::PKT_RAW_ADC) begin
                    if (!count_known) begin
                        n_samples   = b;
                        count_known = 1'b1;
                    end else begin
                        word = word | byte_lane(b, byte_cnt);
                        byte_cnt = byte_cnt + 3'd1;
                        if (byte_cnt >= SAMPLE_BYTES) begin
                            byte_cnt       = '0;
                            fire           = 1'b1;
                            r.record_kind  = lpd_pkg::KIND_RAW;
                            r.sample_value = word;
                            r.sample_index = sample_idx;
                            word           = '0;
                            // a count of zero ends after the first sample
                            if (int'(sample_idx) + 1 >= int'(n_samples)) begin
                                r.last     = 1'b1;
                                sample_idx = '0;
                                phase      = HUNT;
                            end else begin
                                sample_idx = sample_idx + 8'd1;
                            end
                        end
                    end
                end else if (pkt_type == lpd_pkg::PKT_CAL) begin
                    case (cal_field)
                        CAL_PGA: begin
                            pga = b;
                            cal_field = CAL_RAW;
                        end
                        CAL_RAW: begin
                            cal_raw = cal_raw | byte_lane(b, byte_cnt);
                            byte_cnt = byte_cnt + 3'd1;
                            if (byte_cnt >= SAMPLE_BYTES) begin
                                byte_cnt  = '0;
                                cal_field = CAL_CURRENT;
                            end
                        end
                        CAL_CURRENT: begin
                            current = b;
                            cal_field = CAL_STAMP;
                        end
                        default: begin
                            word = word | byte_lane(b, byte_cnt);
                            byte_cnt = byte_cnt + 3'd1;
                            if (byte_cnt >= STAMP_BYTES) begin
                                byte_cnt            = '0;
                                fire                = 1'b1;
                                r.record_kind       = lpd_pkg::KIND_CAL;
                                r.last              = 1'b1;
                                r.gain_level        = pga;
                                r.current_tenths_ma = current;
                                r.cal_raw_value     = cal_raw;
                                r.cal_timestamp     = word;
                                phase               = HUNT;
                            end
                        end
                    endcase
                end else begin
                    // timestamp or unknown type: byte is dropped, back to hunting
                    phase = HUNT;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch on %s: got %0h, predicted %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_beat(input lpd_pkg::lpd_result_t got);
        lpd_pkg::lpd_result_t want;
        if (pending_beats.size() == 0) begin
            report_mismatch("result beat with nothing predicted", got.sample_value, 16'h0);
            return;
        end
        want = pending_beats.pop_front();
        check_field("record_kind", 16'(got.record_kind), 16'(want.record_kind));
        check_field("sample_value", got.sample_value, want.sample_value);
        check_field("sample_index", 16'(got.sample_index), 16'(want.sample_index));
        check_field("last", 16'(got.last), 16'(want.last));
        check_field("gain_level", 16'(got.gain_level), 16'(want.gain_level));
        check_field("current_tenths_ma", 16'(got.current_tenths_ma),
                    16'(want.current_tenths_ma));
        check_field("cal_raw_value", got.cal_raw_value, want.cal_raw_value);
        check_field("cal_timestamp", got.cal_timestamp, want.cal_timestamp);
        if (want.record_kind == lpd_pkg::KIND_CAL)
            cal_cnt++;
        else
            raw_cnt++;
    endtask

    always @(posedge aclk) begin
        lpd_pkg::lpd_result_t beat;
        lpd_pkg::lpd_result_t pred;
        bit fire;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++)
                history[i] = '0;
            hist_ptr = '0;
            phase = HUNT;
            clear_packet();
            pending_beats.delete();
        end else begin
            // output first: a beat leaving now always belongs to an earlier byte
            if (m_tvalid && m_tready) begin
                beat.record_kind       = m_tuser[0];
                beat.sample_value      = m_tdata[15:0];
                beat.sample_index      = m_tdata[23:16];
                beat.gain_level        = m_tdata[31:24];
                beat.current_tenths_ma = m_tdata[39:32];
                beat.cal_raw_value     = m_tdata[55:40];
                beat.cal_timestamp     = m_tdata[71:56];
                beat.last              = m_tlast;
                check_beat(beat);
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, fire, pred);
                if (fire)
                    pending_beats.push_back(pred);
            end
        end
        errors   <= mismatch_cnt;
        pending  <= pending_beats.size();
        raw_seen <= raw_cnt;
        cal_seen <= cal_cnt;
    end

endmodule

FILE: test/log_packet_deframer_top_tb.sv
// testbench top for the log packet deframer: byte stimulus, handshake stalls and verdict
`timescale 1ns / 1ps

module log_packet_deframer_top_tb;

    localparam int SAMPLE_BYTES = 2;
    localparam int STAMP_BYTES  = 2;
    localparam int IDLE_LIMIT   = 500;
    localparam int BYTE_TARGET  = 1150;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic [7:0]                 s_tdata  = 8'h00;
    logic                       m_tready = 1'b0;
    wire                        s_tready;
    wire                        m_tvalid;
    wire [lpd_pkg::TDATA_W-1:0] m_tdata;
    wire [0:0]                  m_tuser;
    wire                        m_tlast;

    int errors;
    int pending;
    int raw_seen;
    int cal_seen;

    bit calm    = 1'b0;
    bit gaps_on = 1'b1;
    int framed_bytes = 0;
    int packets      = 0;
    int odd_packets  = 0;

    log_packet_deframer_top #(
        .SAMPLE_BYTES(SAMPLE_BYTES),
        .STAMP_BYTES (STAMP_BYTES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    log_packet_deframer_checker #(
        .SAMPLE_BYTES(SAMPLE_BYTES),
        .STAMP_BYTES (STAMP_BYTES)
    ) beat_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .errors  (errors),
        .pending (pending),
        .raw_seen(raw_seen),
        .cal_seen(cal_seen)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // receiver: random stall bursts, long open stretches now and then
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 9);
            if (!calm && r < 3) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ((r == 9) ? $urandom_range(40, 120) : $urandom_range(1, 16))
                    @(posedge aclk);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_framed(input logic [7:0] b);
        framed_bytes++;
        send_byte(b);
    endtask

    // fixed fill for directed packets, negative means random content
    function automatic logic [7:0] fill_byte(input int fill);
        return (fill < 0) ? 8'($urandom) : 8'(fill);
    endfunction

    task automatic send_marker();
        send_framed(lpd_pkg::CH_CR);
        send_framed(lpd_pkg::CH_LF);
        send_framed(lpd_pkg::CH_GT);
        send_framed(lpd_pkg::CH_GT);
    endtask

    task automatic send_raw(input int count, input int fill);
        send_marker();
        send_framed(lpd_pkg::PKT_RAW_ADC);
        send_framed(8'($urandom));
        send_framed(8'(count));
        repeat (((count == 0) ? 1 : count) * SAMPLE_BYTES)
            send_framed(fill_byte(fill));
        packets++;
    endtask

    task automatic send_cal(input int fill);
        send_marker();
        send_framed(lpd_pkg::PKT_CAL);
        send_framed(8'($urandom));
        send_framed(fill_byte(fill));
        repeat (SAMPLE_BYTES) send_framed(fill_byte(fill));
        send_framed(fill_byte(fill));
        repeat (STAMP_BYTES) send_framed(fill_byte(fill));
        packets++;
    endtask

    task automatic send_odd(input logic [7:0] kind);
        send_marker();
        send_framed(kind);
        send_framed(8'($urandom));
        send_framed(8'($urandom));
        packets++;
        odd_packets++;
    endtask

    // stray bytes while hunting, biased toward marker characters
    task automatic send_noise(input int n);
        int sel;
        repeat (n) begin
            sel = $urandom_range(0, 3);
            case (sel)
                0:       send_byte(lpd_pkg::CH_CR);
                1:       send_byte(lpd_pkg::CH_LF);
                2:       send_byte(lpd_pkg::CH_GT);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // partial marker, or a packet cut short so later bytes land in its payload
    task automatic send_broken();
        if ($urandom_range(0, 1) == 0) begin
            send_byte(lpd_pkg::CH_CR);
            send_byte(lpd_pkg::CH_LF);
            send_byte(lpd_pkg::CH_GT);
            send_byte(8'($urandom));
        end else begin
            send_marker();
            send_framed($urandom_range(0, 1) ? lpd_pkg::PKT_CAL : lpd_pkg::PKT_RAW_ADC);
            send_framed(8'($urandom));
            repeat ($urandom_range(0, 3)) send_framed(8'($urandom));
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int sel;
        bit big_done;
        bit paused;
        big_done = 1'b0;
        paused   = 1'b0;
        while (!aresetn) @(posedge aclk);

        // zero sample count, all-ones calibration, timestamp type
        send_raw(0, 8'hFF);
        send_cal(8'hFF);
        send_odd(lpd_pkg::PKT_STAMP);
        wait_for_drain();

        while (framed_bytes < BYTE_TARGET) begin
            if (framed_bytes > BYTE_TARGET * 9 / 10)
                calm = 1'b1;
            if ($urandom_range(0, 15) == 0)
                gaps_on = !gaps_on;
            sel = $urandom_range(0, 19);
            if (sel < 9)
                send_raw($urandom_range(0, 10), -1);
            else if (sel < 14)
                send_cal(-1);
            else if (sel < 16)
                send_odd(8'($urandom_range(2, 255)));
            else if (sel < 18)
                send_noise($urandom_range(1, 6));
            else
                send_broken();
            if (!big_done && framed_bytes > 300) begin
                send_raw(255, -1);
                big_done = 1'b1;
            end
            if (!paused && framed_bytes > BYTE_TARGET / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
        end

        wait_for_drain();
        repeat (10) @(posedge aclk);

        $display("sent %0d framed bytes in %0d packets, %0d of them timestamp or unknown type",
                 framed_bytes, packets, odd_packets);
        $display("compared %0d ADC sample beats and %0d calibration beats", raw_seen, cal_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lpd_pkg.sv
rtl/lpd_core.sv
rtl/lpd_out_stage.sv
rtl/log_packet_deframer_top.sv
test/log_packet_deframer_checker.sv
test/log_packet_deframer_top_tb.sv
